### hw/rtl/ccsc_pkg.sv
// shared types and constants for the clock counter with serial commands
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package ccsc_pkg;

  // input event codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_RX    = 2'd1;
  localparam logic [1:0] OP_KEY_A = 2'd2;
  localparam logic [1:0] OP_KEY_B = 2'd3;

  // command byte upper nibbles
  localparam logic [3:0] RX_LED_CMD  = 4'hA;
  localparam logic [3:0] RX_TIME_CMD = 4'hB;

  // configuration register indexes
  localparam logic [1:0] CFG_TICKS_PER_STEP   = 2'd0;
  localparam logic [1:0] CFG_SECONDS_PER_STEP = 2'd1;
  localparam logic [1:0] CFG_HOUR_WRAP        = 2'd2;

  // configuration reset values
  localparam logic [7:0] TICKS_PER_STEP_RST   = 8'd40;
  localparam logic [5:0] SECONDS_PER_STEP_RST = 6'd2;
  localparam logic [6:0] HOUR_WRAP_RST        = 7'd99;

  // time limits and led masks
  localparam logic [6:0] SEC_LIMIT   = 7'd60;
  localparam logic [6:0] MIN_LIMIT   = 7'd60;
  localparam logic [7:0] LED_RST     = 8'hFF;
  localparam logic [7:0] LED_KEY_A   = 8'h40;
  localparam logic [7:0] LED_KEY_B   = 8'h80;

  // result kinds
  localparam logic KIND_LED = 1'b0;
  localparam logic KIND_TX  = 1'b1;

  // time readout phases
  typedef enum logic [2:0] {
    RD_HOURS   = 3'b001,
    RD_MINUTES = 3'b010,
    RD_SECONDS = 3'b100
  } rd_phase_t;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_LED_SET,
    CMD_KEY_A,
    CMD_KEY_B,
    CMD_TIME_RD
  } cmd_t;

  typedef struct packed {
    cmd_t       code;
    logic [3:0] nib;
  } cmd_entry_t;

  typedef struct packed {
    logic [7:0] ticks_per_step;
    logic [5:0] seconds_per_step;
    logic [6:0] hour_wrap;
  } cfg_t;

endpackage

### hw/rtl/ccsc_front.sv
// front end: accepts input events and turns them into queued commands
// depends on ccsc_pkg
`timescale 1ns / 1ps

module ccsc_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_op,
  input  logic [7:0]            in_rx_byte,
  input  logic                  q_full,
  output logic                  push,
  output ccsc_pkg::cmd_entry_t  entry
);

  logic keep;

  assign in_stall = q_full;

  always_comb begin
    entry.nib  = in_rx_byte[3:0];
    entry.code = ccsc_pkg::CMD_TICK;
    keep       = 1'b1;
    case (in_op)
      ccsc_pkg::OP_TICK: begin
        entry.code = ccsc_pkg::CMD_TICK;
      end
      ccsc_pkg::OP_RX: begin
        // unknown bytes are dropped here
        if (in_rx_byte[7:4] == ccsc_pkg::RX_LED_CMD) begin
          entry.code = ccsc_pkg::CMD_LED_SET;
        end else if (in_rx_byte[7:4] == ccsc_pkg::RX_TIME_CMD) begin
          entry.code = ccsc_pkg::CMD_TIME_RD;
        end else begin
          keep = 1'b0;
        end
      end
      ccsc_pkg::OP_KEY_A: begin
        entry.code = ccsc_pkg::CMD_KEY_A;
      end
      default: begin
        entry.code = ccsc_pkg::CMD_KEY_B;
      end
    endcase
  end

  assign push = in_valid && !q_full && keep;

endmodule

### hw/rtl/ccsc_queue.sv
// command queue between front and back end
// depends on ccsc_pkg
`timescale 1ns / 1ps

module ccsc_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ccsc_pkg::cmd_entry_t  push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output ccsc_pkg::cmd_entry_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ccsc_pkg::cmd_entry_t q_mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hw/rtl/ccsc_back.sv
// back end: keeps time and led state, executes commands, drives results
// depends on ccsc_pkg
`timescale 1ns / 1ps

module ccsc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ccsc_pkg::cfg_t        cfg,
  input  logic                  head_valid,
  input  ccsc_pkg::cmd_entry_t  head,
  output logic                  pop,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic                  out_kind,
  output logic [7:0]            out_data,
  output logic                  out_last
);

  // binary to packed bcd, x/10 as (x*205)>>11
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 15'(v) * 15'd205;
    tens  = prod[14:11];
    units = v - 7'(tens) * 7'd10;
    return {tens, 4'b0000} + {4'b0000, units[3:0]};
  endfunction

  logic [7:0] prescale_r, prescale_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic [5:0] min_r, min_nxt;
  logic [6:0] hr_r, hr_nxt;
  logic [7:0] led_r, led_nxt;
  ccsc_pkg::rd_phase_t phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_kind_r, out_kind_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;

  logic       can_load;
  logic       load;
  logic [7:0] p_inc;
  logic       fill;
  logic [6:0] sec_sum;
  logic       sec_wrap;
  logic [6:0] min_sum;
  logic       min_wrap;
  logic [7:0] hr_sum;

  assign can_load = !out_valid_r || !out_stall;

  // tick arithmetic
  always_comb begin
    p_inc    = prescale_r + 8'd1;
    fill     = (p_inc >= cfg.ticks_per_step);
    sec_sum  = {1'b0, sec_r} + (fill ? {1'b0, cfg.seconds_per_step} : 7'd0);
    sec_wrap = (sec_sum >= ccsc_pkg::SEC_LIMIT);
    min_sum  = {1'b0, min_r} + {6'd0, sec_wrap};
    min_wrap = (min_sum >= ccsc_pkg::MIN_LIMIT);
    hr_sum   = {1'b0, hr_r} + {7'd0, min_wrap};
  end

  always_comb begin
    prescale_nxt  = prescale_r;
    sec_nxt       = sec_r;
    min_nxt       = min_r;
    hr_nxt        = hr_r;
    led_nxt       = led_r;
    phase_nxt     = phase_r;
    pop           = 1'b0;
    load          = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (head_valid) begin
      case (head.code)
        ccsc_pkg::CMD_TICK: begin
          pop          = 1'b1;
          prescale_nxt = fill ? 8'd0 : p_inc;
          sec_nxt      = sec_wrap ? 6'd0 : sec_sum[5:0];
          min_nxt      = min_wrap ? 6'd0 : min_sum[5:0];
          hr_nxt       = (hr_sum >= {1'b0, cfg.hour_wrap}) ? 7'd0 : hr_sum[6:0];
        end
        ccsc_pkg::CMD_LED_SET, ccsc_pkg::CMD_KEY_A, ccsc_pkg::CMD_KEY_B: begin
          if (can_load) begin
            pop  = 1'b1;
            load = 1'b1;
            case (head.code)
              ccsc_pkg::CMD_LED_SET: led_nxt = {led_r[7:4], ~head.nib};
              ccsc_pkg::CMD_KEY_A:   led_nxt = led_r ^ ccsc_pkg::LED_KEY_A;
              default:               led_nxt = led_r ^ ccsc_pkg::LED_KEY_B;
            endcase
            out_kind_nxt = ccsc_pkg::KIND_LED;
            out_data_nxt = led_nxt;
            out_last_nxt = 1'b1;
          end
        end
        default: begin
          // time readout, one bcd byte per cycle while the output is not stalled
          if (can_load) begin
            load         = 1'b1;
            out_kind_nxt = ccsc_pkg::KIND_TX;
            out_last_nxt = 1'b0;
            case (phase_r)
              ccsc_pkg::RD_HOURS: begin
                out_data_nxt = to_bcd(hr_r);
                phase_nxt    = ccsc_pkg::RD_MINUTES;
              end
              ccsc_pkg::RD_MINUTES: begin
                out_data_nxt = to_bcd({1'b0, min_r});
                phase_nxt    = ccsc_pkg::RD_SECONDS;
              end
              default: begin
                out_data_nxt = to_bcd({1'b0, sec_r});
                out_last_nxt = 1'b1;
                phase_nxt    = ccsc_pkg::RD_HOURS;
                pop          = 1'b1;
              end
            endcase
          end
        end
      endcase
    end
    out_valid_nxt = can_load ? load : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r  <= 8'd0;
      sec_r       <= 6'd0;
      min_r       <= 6'd0;
      hr_r        <= 7'd0;
      led_r       <= ccsc_pkg::LED_RST;
      phase_r     <= ccsc_pkg::RD_HOURS;
      out_valid_r <= 1'b0;
    end else begin
      prescale_r  <= prescale_nxt;
      sec_r       <= sec_nxt;
      min_r       <= min_nxt;
      hr_r        <= hr_nxt;
      led_r       <= led_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

### hw/rtl/clock_counter_with_serial_commands_core.sv
// top level of the clock counter with serial commands
// depends on ccsc_pkg, ccsc_front, ccsc_queue and ccsc_back
`timescale 1ns / 1ps

// Hours:minutes:seconds counter with an active-low 8-bit led pattern, driven
// by one event per input transaction: prescaler ticks, received command bytes
// (0xAn sets the led low nibble to ~n and reports the pattern, 0xBn sends
// hours, minutes and seconds as three bcd bytes) and two key releases that
// toggle led bits 6 and 7 and report the pattern. The front end takes one
// transaction per cycle while the queue is not full and drops unknown bytes;
// all others enter a QUEUE_DEPTH-entry command queue. The back end retires a
// tick even under an output stall, a led command when the output register
// loads and a time request once its three bcd bytes are loaded. Input
// stalls only while the queue is full, so sustained rate is one transaction
// per cycle apart from the extra bytes of time requests and output stalls.
// Each result is registered from the command at the queue head, held back
// by output stalls. Configuration writes are always ready and take effect
// from the next cycle; write them only while no transaction is in flight.

module clock_counter_with_serial_commands_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  // input events
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [7:0] in_rx_byte,
  // results
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_data,
  output logic       out_last,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  ccsc_pkg::cfg_t       cfg_r, cfg_nxt;
  ccsc_pkg::cmd_entry_t push_entry;
  ccsc_pkg::cmd_entry_t head_entry;
  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 head_valid;

  // configuration registers, written whenever valid is high
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ccsc_pkg::CFG_TICKS_PER_STEP:   cfg_nxt.ticks_per_step   = cfg_data;
        ccsc_pkg::CFG_SECONDS_PER_STEP: cfg_nxt.seconds_per_step = cfg_data[5:0];
        ccsc_pkg::CFG_HOUR_WRAP:        cfg_nxt.hour_wrap        = cfg_data[6:0];
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_step   <= ccsc_pkg::TICKS_PER_STEP_RST;
      cfg_r.seconds_per_step <= ccsc_pkg::SECONDS_PER_STEP_RST;
      cfg_r.hour_wrap        <= ccsc_pkg::HOUR_WRAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // classify events, drop unknown bytes
  ccsc_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (q_push),
    .entry      (push_entry)
  );

  // decouples input acceptance from result back-pressure
  ccsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head       (head_entry)
  );

  // time keeping, led state and result register
  ccsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head       (head_entry),
    .pop        (q_pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_kind   (out_kind),
    .out_data   (out_data),
    .out_last   (out_last)
  );

  // led results always come alone
  a_led_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == ccsc_pkg::KIND_LED) |-> out_last)
    else $error("led result without last");

  // bcd bytes of one time request follow back to back
  a_tx_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_kind == ccsc_pkg::KIND_TX && !out_last)
      |=> (out_valid && out_kind == ccsc_pkg::KIND_TX))
    else $error("time readout burst broken");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // nothing enters the queue while the input is stalled
  a_no_push_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !q_push)
    else $error("queue push while stalled");

endmodule

### tb/clock_readout_checker.sv
// checker for the clock counter with serial commands: tracks the register
// writes, predicts led and bcd readouts and compares them as they leave
// depends on ccsc_pkg only
`timescale 1ns / 1ps

module clock_readout_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_kind,
  input  logic [7:0] out_data,
  input  logic       out_last,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         readouts_due,
  output int         fail_count
);

  typedef struct {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } readout_t;

  readout_t       expected_readouts[$];
  ccsc_pkg::cfg_t settings;
  logic [7:0]     prescaler;
  logic [5:0]     secs;
  logic [5:0]     mins;
  logic [6:0]     hrs;
  logic [7:0]     leds;

  // tens stay below 13 for 7-bit hours, so the nibble pair is exact
  function automatic logic [7:0] bcd_byte(input logic [6:0] v);
    logic [3:0] tens;
    logic [3:0] units;
    tens  = 4'(v / 7'd10);
    units = 4'(v % 7'd10);
    return {tens, units};
  endfunction

  task automatic push_readout(input logic kind, input logic [7:0] data, input logic last);
    readout_t r;
    r.kind = kind;
    r.data = data;
    r.last = last;
    expected_readouts.push_back(r);
  endtask

  task automatic advance_time();
    logic [6:0] s;
    logic [6:0] m;
    logic [7:0] h;
    prescaler = prescaler + 8'd1;
    s = {1'b0, secs};
    if (prescaler >= settings.ticks_per_step) begin
      prescaler = '0;
      s = s + {1'b0, settings.seconds_per_step};
    end
    m = {1'b0, mins};
    h = {1'b0, hrs};
    // overshoot is dropped, not carried
    if (s >= ccsc_pkg::SEC_LIMIT) begin
      s = '0;
      m = m + 7'd1;
    end
    if (m >= ccsc_pkg::MIN_LIMIT) begin
      m = '0;
      h = h + 8'd1;
    end
    if (h >= {1'b0, settings.hour_wrap}) h = '0;
    secs = s[5:0];
    mins = m[5:0];
    hrs  = h[6:0];
  endtask

  task automatic apply_event(input logic [1:0] op, input logic [7:0] rx);
    case (op)
      ccsc_pkg::OP_TICK: advance_time();
      ccsc_pkg::OP_RX: begin
        if (rx[7:4] == ccsc_pkg::RX_LED_CMD) begin
          leds = {leds[7:4], ~rx[3:0]};
          push_readout(ccsc_pkg::KIND_LED, leds, 1'b1);
        end else if (rx[7:4] == ccsc_pkg::RX_TIME_CMD) begin
          push_readout(ccsc_pkg::KIND_TX, bcd_byte(hrs), 1'b0);
          push_readout(ccsc_pkg::KIND_TX, bcd_byte({1'b0, mins}), 1'b0);
          push_readout(ccsc_pkg::KIND_TX, bcd_byte({1'b0, secs}), 1'b1);
        end
      end
      ccsc_pkg::OP_KEY_A: begin
        leds = leds ^ ccsc_pkg::LED_KEY_A;
        push_readout(ccsc_pkg::KIND_LED, leds, 1'b1);
      end
      default: begin
        leds = leds ^ ccsc_pkg::LED_KEY_B;
        push_readout(ccsc_pkg::KIND_LED, leds, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin : monitor
    readout_t want;
    if (!rst_n) begin
      settings.ticks_per_step   = ccsc_pkg::TICKS_PER_STEP_RST;
      settings.seconds_per_step = ccsc_pkg::SECONDS_PER_STEP_RST;
      settings.hour_wrap        = ccsc_pkg::HOUR_WRAP_RST;
      prescaler = '0;
      secs      = '0;
      mins      = '0;
      hrs       = '0;
      leds      = ccsc_pkg::LED_RST;
      expected_readouts.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ccsc_pkg::CFG_TICKS_PER_STEP:   settings.ticks_per_step   = cfg_data;
          ccsc_pkg::CFG_SECONDS_PER_STEP: settings.seconds_per_step = cfg_data[5:0];
          ccsc_pkg::CFG_HOUR_WRAP:        settings.hour_wrap        = cfg_data[6:0];
          default: ;
        endcase
      end
      // result side first so a readout can never match its own input's transaction
      if (out_valid && !out_stall) begin
        if (expected_readouts.size() == 0) begin
          $error("unexpected result: kind %0d data %02h last %0d",
                 out_kind, out_data, out_last);
          fail_count++;
        end else begin
          want = expected_readouts.pop_front();
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_kind);
            fail_count++;
          end
          if (out_data !== want.data) begin
            $error("data: expected %02h, actual %02h", want.data, out_data);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_last);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) apply_event(in_op, in_rx_byte);
    end
    readouts_due = expected_readouts.size();
  end

endmodule

### tb/tb_top.sv
// top of the testbench for the clock counter with serial commands
// drives events and register writes, idles both sides; checking lives in
// clock_readout_checker; depends on ccsc_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_top;

  // queue depth plus a three-byte readout plus output register, with margin
  localparam int SETTLE_CYCLES   = 16;
  // longest quiet stretch of a correct run is a long gap, a long stall and
  // a settle pause; this is many times that
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_EVENTS    = 30;
  // enough one-minute ticks to carry minutes into hours twice
  localparam int LONG_RUN_EVENTS = 140;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [1:0] in_op      = ccsc_pkg::OP_TICK;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_stall  = 1'b0;
  logic       cfg_valid  = 1'b0;
  logic [1:0] cfg_index  = ccsc_pkg::CFG_TICKS_PER_STEP;
  logic [7:0] cfg_data   = 8'h00;
  logic       in_stall;
  logic       out_valid;
  logic       out_kind;
  logic [7:0] out_data;
  logic       out_last;
  logic       cfg_ready;

  int readouts_due;
  int mismatch_count;
  int quiet_cycles = 0;
  int stall_hold   = 0;
  bit gaps_on      = 1'b0;
  bit stalls_on    = 1'b0;

  always #5 clk = ~clk;

  clock_counter_with_serial_commands_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_data   (out_data),
    .out_last   (out_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  clock_readout_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_data     (out_data),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .readouts_due (readouts_due),
    .fail_count   (mismatch_count)
  );

  // idle stretch: mostly short, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // result side backpressure: alternating free and stalled stretches
  always @(posedge clk) begin
    if (!stalls_on) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (out_stall) begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 12);
    end else begin
      out_stall  <= 1'b1;
      stall_hold <= idle_len() - 1;
    end
  end

  // watchdog: any accepted transaction on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one event transaction; valid stays high afterwards so back-to-back
  // events never lower and raise it in the same step
  task automatic send_event(input logic [1:0] op, input logic [7:0] rx);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 9) >= 6) gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_rx_byte <= rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // mix of ticks, led and time commands, junk bytes and key releases
  task automatic send_random_event(input int tick_pct);
    logic [7:0] rx;
    rx = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < tick_pct) begin
      send_event(ccsc_pkg::OP_TICK, rx);
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_event(ccsc_pkg::OP_RX, {ccsc_pkg::RX_LED_CMD, rx[3:0]});
        3, 4, 5: send_event(ccsc_pkg::OP_RX, {ccsc_pkg::RX_TIME_CMD, rx[3:0]});
        6:       send_event(ccsc_pkg::OP_RX, 8'h00);
        7:       send_event(ccsc_pkg::OP_RX, rx);
        8:       send_event(ccsc_pkg::OP_KEY_A, rx);
        default: send_event(ccsc_pkg::OP_KEY_B, rx);
      endcase
    end
  endtask

  // block must be idle: every readout in, then time for queued ticks to retire
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (readouts_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write; valid left high for the next write
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(input logic [7:0] tps, input logic [7:0] sps,
                               input logic [7:0] hw);
    settle();
    write_reg(ccsc_pkg::CFG_TICKS_PER_STEP, tps);
    write_reg(ccsc_pkg::CFG_SECONDS_PER_STEP, sps);
    write_reg(ccsc_pkg::CFG_HOUR_WRAP, hw);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n     <= 1'b1;
    stalls_on <= 1'b1;

    // directed, reset settings: keys toggle bits 6 and 7 both ways
    send_event(ccsc_pkg::OP_KEY_A, 8'hFF);
    send_event(ccsc_pkg::OP_KEY_B, 8'h00);
    send_event(ccsc_pkg::OP_KEY_A, 8'h00);
    send_event(ccsc_pkg::OP_KEY_B, 8'hFF);
    // led nibble extremes, time readout extremes, ignored bytes incl. zero
    send_event(ccsc_pkg::OP_RX, 8'hA0);
    send_event(ccsc_pkg::OP_RX, 8'hAF);
    send_event(ccsc_pkg::OP_RX, 8'hA5);
    send_event(ccsc_pkg::OP_RX, 8'hB0);
    send_event(ccsc_pkg::OP_RX, 8'hBF);
    send_event(ccsc_pkg::OP_RX, 8'h00);
    send_event(ccsc_pkg::OP_RX, 8'hFF);
    send_event(ccsc_pkg::OP_RX, 8'h5A);
    send_event(ccsc_pkg::OP_RX, 8'hC3);
    // ticks carry junk in rx_byte, which must be ignored
    send_event(ccsc_pkg::OP_TICK, 8'hFF);
    send_event(ccsc_pkg::OP_TICK, 8'h00);
    send_event(ccsc_pkg::OP_RX, 8'hB7);

    // all-zero registers: prescaler fills every tick, seconds never move,
    // hours forced to zero
    load_settings(8'd0, 8'd0, 8'd0);
    send_event(ccsc_pkg::OP_TICK, 8'hA1);
    send_event(ccsc_pkg::OP_TICK, 8'hB2);
    send_event(ccsc_pkg::OP_RX, 8'hB3);

    // seconds per step and hour wrap topped by full 8-bit writes, ticks per
    // step zero: seconds overshoot and drop the excess, one minute per tick
    load_settings(8'd0, 8'hFF, 8'hFF);
    send_event(ccsc_pkg::OP_TICK, 8'h55);
    send_event(ccsc_pkg::OP_TICK, 8'hAA);
    send_event(ccsc_pkg::OP_TICK, 8'h0F);
    send_event(ccsc_pkg::OP_RX, 8'hB4);

    // long run on the same settings: minutes carry into hours, with sparse
    // readouts along the way
    for (int n = 0; n < LONG_RUN_EVENTS; n++) begin
      if ($urandom_range(0, 49) == 0) send_random_event(0);
      else send_event(ccsc_pkg::OP_TICK, 8'($urandom_range(0, 255)));
    end

    // random phases, one register setting each
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        // hour wrap below the hours left by the long run
        0: load_settings(8'd1, 8'd59, 8'd1);
        1: load_settings(8'd255, 8'd1, 8'd99);
        2: load_settings(8'd0, 8'd45, 8'd2);
        3: load_settings(8'd2, 8'd30, 8'd1);
        default: load_settings(8'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
      endcase
      // some phases run with no idling on one side or the other
      gaps_on   = (phase % 3 != 2);
      stalls_on <= (phase % 4 != 3);
      for (int n = 0; n < PHASE_EVENTS; n++) send_random_event(55);
    end

    settle();
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
